// ===== design/fcc_pkg.sv =====
`timescale 1ns / 1ps

package fcc_pkg;

    // request kinds
    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_LOOKUP = 1'b1
    } kind_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DATA_AREA_START     = 1'b0,
        REG_SECTORS_PER_CLUSTER = 1'b1
    } cfg_reg_t;

    // smallest next-cluster code that marks end of chain
    localparam logic [11:0] FAT12_EOC_MIN = 12'hFF8;

    // one request
    typedef struct packed {
        kind_t       kind;
        logic [12:0] table_address;
        logic [7:0]  table_byte;
        logic [11:0] cluster;
    } req_t;

    // one result
    typedef struct packed {
        logic [31:0] cluster_sector;
        logic [11:0] next_cluster;
        logic        end_of_chain;
        logic        not_ready;
    } res_t;

endpackage

// ===== design/fat12_cluster_chain_step.sv =====
`timescale 1ns / 1ps

// FAT12 cluster chain step.
// Requests arrive on req_valid / req_stall / req_data. A write request stores
// one allocation table byte and gives no result; a lookup request gives one
// result on res_valid / res_stall / res_data with the cluster's first sector,
// the next cluster from the table, an end-of-chain flag and a not-ready flag.
// Configuration (data area start, sectors per cluster) must be written by
// the user via cfg_we / cfg_index / cfg_data while no request is in flight;
// the block does not enforce this. The table sits in two byte-wide banks
// (even and odd addresses), so the two bytes of a lookup are read in the
// same cycle from the two single-port rams. A lookup passes from the bank
// read registers through the read stage into the result register.
// Throughput: one request per cycle while req_stall is low, set by the one
// ram access per bank per cycle; writes and lookups may mix freely.
// When res_stall holds a result, one more lookup waits in the read stage and
// then req_stall rises until the result is taken.
// Reset clears the valid flags and the configuration registers (data area
// start 0, one sector per cluster); the table content is not cleared and
// must be written before it is looked up.
module fat12_cluster_chain_step
    import fcc_pkg::*;
#(
    parameter int unsigned TABLE_BYTES = 8192
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output res_t                   res_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned AW         = $clog2(TABLE_BYTES);
    localparam int unsigned RW         = AW - 1;
    localparam int unsigned BANK_DEPTH = 1 << RW;

    // configuration registers
    logic [31:0] das_reg;
    logic [7:0]  spc_reg;

    // read stage
    logic        s1_valid_reg;
    logic        s1_idx_odd_reg;
    logic        s1_clus_odd_reg;
    logic [31:0] s1_product_reg;

    // result register
    logic        res_valid_reg;
    res_t        res_reg;

    logic          req_take;
    logic          is_write;
    logic          is_lookup;
    logic          s1_go;
    logic [12:0]   idx;
    logic [AW-1:0] idx_ext;
    logic [AW-1:0] wr_ext;
    logic [RW-1:0] lo_row;
    logic [RW-1:0] lo_row_p1;
    logic [RW-1:0] wr_row;
    logic          idx_odd;
    logic [31:0]   offset;
    logic [31:0]   product;
    logic          even_en;
    logic          odd_en;
    logic [RW-1:0] even_addr;
    logic [RW-1:0] odd_addr;
    logic [7:0]    even_rdata;
    logic [7:0]    odd_rdata;
    logic [7:0]    byte_lo;
    logic [7:0]    byte_hi;
    logic [15:0]   word;
    logic [11:0]   next_cl;
    res_t          res_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            das_reg <= 32'd0;
            spc_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DATA_AREA_START:     das_reg <= cfg_data;
                REG_SECTORS_PER_CLUSTER: spc_reg <= cfg_data[7:0];
                default:                 das_reg <= das_reg;
            endcase
        end
    end

    // handshake: read stage moves when the result register is empty or taken
    assign s1_go     = !res_valid_reg || !res_stall;
    assign req_stall = s1_valid_reg && !s1_go;
    assign req_take  = req_valid && !req_stall;
    assign is_lookup = req_take && (req_data.kind == KIND_LOOKUP);
    assign is_write  = req_take && (req_data.kind == KIND_WRITE)
                       && (32'(req_data.table_address) < 32'(TABLE_BYTES));

    // byte index of the table entry: cluster * 3 / 2
    assign idx       = {1'b0, req_data.cluster} + {2'b00, req_data.cluster[11:1]};
    assign idx_ext   = AW'(idx);
    assign idx_odd   = idx[0];
    assign lo_row    = idx_ext[AW-1:1];
    assign lo_row_p1 = RW'(lo_row + 1'b1);
    assign wr_ext    = AW'(req_data.table_address);
    assign wr_row    = wr_ext[AW-1:1];

    // bank select: low byte and high byte always sit in different banks
    assign even_en   = is_lookup || (is_write && !req_data.table_address[0]);
    assign odd_en    = is_lookup || (is_write && req_data.table_address[0]);
    assign even_addr = is_write ? wr_row : (idx_odd ? lo_row_p1 : lo_row);
    assign odd_addr  = is_write ? wr_row : lo_row;

    fcc_ram #(
        .WIDTH  (8),
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (RW)
    ) u_even_bank (
        .clk   (clk),
        .en    (even_en),
        .we    (is_write),
        .addr  (even_addr),
        .wdata (req_data.table_byte),
        .rdata (even_rdata)
    );

    fcc_ram #(
        .WIDTH  (8),
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (RW)
    ) u_odd_bank (
        .clk   (clk),
        .en    (odd_en),
        .we    (is_write),
        .addr  (odd_addr),
        .wdata (req_data.table_byte),
        .rdata (odd_rdata)
    );

    // sector offset, wraps for clusters below two
    assign offset  = 32'(req_data.cluster) - 32'd2;
    assign product = offset * {24'd0, spc_reg};

    // read stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            s1_valid_reg <= is_lookup;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_lookup)
        begin
            s1_idx_odd_reg  <= idx_odd;
            s1_clus_odd_reg <= req_data.cluster[0];
            s1_product_reg  <= product;
        end
    end

    // assemble the 16-bit word and pick the 12-bit entry
    assign byte_lo = s1_idx_odd_reg ? odd_rdata : even_rdata;
    assign byte_hi = s1_idx_odd_reg ? even_rdata : odd_rdata;
    assign word    = {byte_hi, byte_lo};
    assign next_cl = s1_clus_odd_reg ? word[15:4] : word[11:0];

    always_comb
    begin
        if (das_reg == 32'd0)
        begin
            res_next.cluster_sector = 32'd0;
            res_next.next_cluster   = 12'd0;
            res_next.end_of_chain   = 1'b0;
            res_next.not_ready      = 1'b1;
        end
        else
        begin
            res_next.cluster_sector = das_reg + s1_product_reg;
            res_next.next_cluster   = next_cl;
            res_next.end_of_chain   = (next_cl >= FAT12_EOC_MIN);
            res_next.not_ready      = 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef SYNTHESIS
    // an accepted lookup always reaches the read stage
    a_lookup_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_data.kind == KIND_LOOKUP) |=> s1_valid_reg)
        else $error("accepted lookup did not enter read stage");

    // a held read stage keeps its lookup and its bank data
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_product_reg)
                                      && $stable(even_rdata) && $stable(odd_rdata)))
        else $error("read stage changed while held");

    // requests are held back only when both stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && res_valid_reg))
        else $error("request stall with a free stage");

    // a write request never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_data.kind == KIND_WRITE && !s1_valid_reg)
        |=> !s1_valid_reg)
        else $error("write request entered the read stage");
`endif

endmodule

// ===== design/fcc_ram.sv =====
`timescale 1ns / 1ps

module fcc_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read, read data holds when idle or writing
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/fcc_chain_checker.sv =====
`timescale 1ns / 1ps

module fcc_chain_checker
    import fcc_pkg::*;
#(
    parameter int unsigned TABLE_BYTES = 8192
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_stall,
    input  req_t                   req_data,
    input  logic                   res_valid,
    input  logic                   res_stall,
    input  res_t                   res_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    // shadow copy of the allocation table and the configuration
    logic [7:0]  fat_image [TABLE_BYTES];
    logic [31:0] area_start;
    logic [7:0]  sectors_per_clus;
    res_t        expected_results [$];
    int          errors;

    // table bytes past the end read as zero
    function automatic logic [7:0] fat_byte(input int unsigned addr);
        if (addr < TABLE_BYTES)
        begin
            return fat_image[addr];
        end
        return 8'h00;
    endfunction

    // first sector and next-cluster entry for one lookup
    function automatic res_t predict_chain_step(input logic [11:0] cluster);
        res_t        r;
        int unsigned idx;
        logic [15:0] word;
        r = '0;
        if (area_start == 32'd0)
        begin
            r.not_ready = 1'b1;
            return r;
        end
        r.cluster_sector = area_start + ({20'd0, cluster} - 32'd2) * {24'd0, sectors_per_clus};
        idx = ({20'd0, cluster} * 32'd3) >> 1;
        word = {fat_byte(idx + 1), fat_byte(idx)};
        r.next_cluster = cluster[0] ? word[15:4] : word[11:0];
        r.end_of_chain = (r.next_cluster >= FAT12_EOC_MIN);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            area_start = 32'd0;
            sectors_per_clus = 8'd1;
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == REG_DATA_AREA_START)
                begin
                    area_start = cfg_data;
                end
                else if (cfg_index == REG_SECTORS_PER_CLUSTER)
                begin
                    sectors_per_clus = cfg_data[7:0];
                end
            end

            // results are matched before this edge's request is queued
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, actual sector %h next %h eoc %b nr %b",
                             $time, res_data.cluster_sector, res_data.next_cluster,
                             res_data.end_of_chain, res_data.not_ready);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_data !== want)
                    begin
                        errors++;
                        $display("%0t: result mismatch, expected sector %h next %h eoc %b nr %b",
                                 $time, want.cluster_sector, want.next_cluster,
                                 want.end_of_chain, want.not_ready);
                        $display("%0t:                   actual sector %h next %h eoc %b nr %b",
                                 $time, res_data.cluster_sector, res_data.next_cluster,
                                 res_data.end_of_chain, res_data.not_ready);
                    end
                end
            end

            // accepted requests
            if (req_valid && !req_stall)
            begin
                if (req_data.kind == KIND_WRITE)
                begin
                    if (req_data.table_address < TABLE_BYTES)
                    begin
                        fat_image[req_data.table_address] = req_data.table_byte;
                    end
                end
                else
                begin
                    expected_results.push_back(predict_chain_step(req_data.cluster));
                end
            end

            fail_count <= errors;
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import fcc_pkg::*;

    localparam int unsigned TABLE_BYTES    = 8192;
    localparam int          PHASE_ITEMS    = 300;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          WATCHDOG_LIMIT = 4000;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_t                   req_data;
    logic                   res_valid;
    logic                   res_stall;
    res_t                   res_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   fail_count;
    int   pending;
    logic steady;
    bit   written [TABLE_BYTES];
    int   stall_left;
    int   quiet_cycles;
    int   sent_items;

    fat12_cluster_chain_step #(
        .TABLE_BYTES(TABLE_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fcc_chain_checker #(
        .TABLE_BYTES(TABLE_BYTES)
    ) chain_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_hold();
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(25, 70);
    endfunction

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_stall <= 1'b0;
            stall_left <= pick_hold();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** fat12_cluster_chain_step: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request, held until accepted; the caller drives req_valid next
    task automatic send_req(input req_t r);
        int gap;
        gap = pick_hold();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do @(posedge clk); while (req_stall);
        sent_items++;
    endtask

    task automatic store_byte(input logic [12:0] addr, input logic [7:0] value);
        req_t r;
        r = req_t'({$urandom, $urandom});
        r.kind = KIND_WRITE;
        r.table_address = addr;
        r.table_byte = value;
        written[addr] = 1'b1;
        send_req(r);
    endtask

    task automatic look_up(input logic [11:0] cluster);
        req_t r;
        r = req_t'({$urandom, $urandom});
        r.kind = KIND_LOOKUP;
        r.cluster = cluster;
        send_req(r);
    endtask

    // wait for every result, let writes settle, then set both registers
    task automatic reconfigure(input logic [31:0] area_start, input logic [7:0] spc);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_DATA_AREA_START;
        cfg_data <= area_start;
        @(posedge clk);
        cfg_index <= REG_SECTORS_PER_CLUSTER;
        cfg_data <= {24'd0, spc};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic bit covered(input logic [11:0] cluster);
        int unsigned idx;
        idx = ({20'd0, cluster} * 32'd3) >> 1;
        return written[idx] && written[idx + 1];
    endfunction

    // fill the entry of a cluster (often end of chain), then look it up
    task automatic chain_step(input logic [11:0] cluster);
        int unsigned idx;
        logic [11:0] entry;
        logic [7:0]  lo;
        logic [7:0]  hi;
        idx = ({20'd0, cluster} * 32'd3) >> 1;
        if (!covered(cluster) || $urandom_range(0, 1) == 1)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                entry = FAT12_EOC_MIN + 12'($urandom_range(0, 7));
            end
            else
            begin
                entry = 12'($urandom);
            end
            if (cluster[0])
            begin
                lo = {entry[3:0], 4'($urandom)};
                hi = entry[11:4];
            end
            else
            begin
                lo = entry[7:0];
                hi = {4'($urandom), entry[11:8]};
            end
            store_byte(13'(idx), lo);
            store_byte(13'(idx + 1), hi);
        end
        look_up(cluster);
    endtask

    function automatic logic [11:0] pick_cluster();
        logic [11:0] edges [5];
        edges = '{12'd0, 12'd1, 12'd2, 12'd4094, 12'd4095};
        if ($urandom_range(0, 9) == 0)
        begin
            return edges[$urandom_range(0, 4)];
        end
        return 12'($urandom);
    endfunction

    // stimulus
    initial
    begin
        logic [31:0] area_set [6];
        logic [7:0]  spc_set [6];
        logic [11:0] c;
        int          r;
        int          tries;
        int          phase_start;

        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_DATA_AREA_START;
        cfg_data = '0;
        steady = 1'b0;
        sent_items = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // not set up after reset
        store_byte(13'd3, 8'hFF);
        store_byte(13'd4, 8'hFF);
        look_up(12'd2);

        // extreme registers, clusters below two wrap
        reconfigure(32'hFFFF_FFFF, 8'd128);
        store_byte(13'd0, 8'hF8);
        store_byte(13'd1, 8'hFF);
        store_byte(13'd2, 8'hFF);
        look_up(12'd0);
        look_up(12'd1);
        // top of the cluster range
        store_byte(13'd6141, 8'hAB);
        store_byte(13'd6142, 8'hCD);
        store_byte(13'd6143, 8'hEF);
        look_up(12'd4094);
        look_up(12'd4095);
        store_byte(13'd8191, 8'h55);
        store_byte(13'd4096, 8'hAA);
        look_up(12'd2);
        // just below and at end of chain
        store_byte(13'd15, 8'hF7);
        store_byte(13'd16, 8'h0F);
        look_up(12'd10);
        store_byte(13'd15, 8'hF8);
        look_up(12'd10);

        // zero sectors per cluster
        reconfigure(32'd1, 8'd0);
        look_up(12'd0);
        look_up(12'd10);

        // random phases over several register settings
        area_set = '{32'd1, 32'hFFFF_FFFF, 32'd0, $urandom, $urandom, $urandom};
        spc_set = '{8'd1, 8'd255, 8'($urandom_range(1, 128)), 8'd0, 8'd128,
                    8'($urandom_range(1, 128))};
        for (int p = 0; p < 6; p++)
        begin
            reconfigure(area_set[p], spc_set[p]);
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    steady <= ($urandom_range(0, 3) == 0);
                end
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    chain_step(pick_cluster());
                end
                else if (r < 75)
                begin
                    // revisit a cluster whose entry is already in the table
                    c = pick_cluster();
                    tries = 0;
                    while (!covered(c) && tries < 8)
                    begin
                        c = pick_cluster();
                        tries++;
                    end
                    if (covered(c))
                    begin
                        look_up(c);
                    end
                    else
                    begin
                        chain_step(c);
                    end
                end
                else
                begin
                    store_byte(13'($urandom), 8'($urandom));
                end
            end
        end

        // drain and verdict
        steady <= 1'b0;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** fat12_cluster_chain_step: PASSED **");
        end
        else
        begin
            $display("** fat12_cluster_chain_step: FAILED **");
        end
        $finish;
    end

endmodule
